FILE: rtl/paged_frame_buffer_line_draw_unit_macros.svh
// Assertion macros shared by the checker of the line draw unit.
// Included by file name; no other dependencies.
`ifndef PAGED_FRAME_BUFFER_LINE_DRAW_UNIT_MACROS_SVH
`define PAGED_FRAME_BUFFER_LINE_DRAW_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define PFB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define PFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pfb_pkg.sv
// Shared types and codes of the paged frame buffer line draw unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pfb_pkg;

	// Request opcodes
	typedef enum logic [2:0] {
		OP_WRITE_BYTE   = 3'd0,
		OP_READ_BYTE    = 3'd1,
		OP_PIXEL_ON     = 3'd2,
		OP_PIXEL_OFF    = 3'd3,
		OP_PIXEL_TOGGLE = 3'd4,
		OP_LINE         = 3'd5,
		OP_CLEAR_ALL    = 3'd6,
		OP_CLEAR_PAGE   = 3'd7
	} pfb_op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_COL_A = 3'd1,
		ST_BAD_COL_B = 3'd2,
		ST_BAD_ROW_A = 3'd3,
		ST_BAD_ROW_B = 3'd4
	} pfb_status_t;

	// Work kinds handed from the front end to the engine
	typedef enum logic [2:0] {
		KIND_STATUS,
		KIND_WRITE,
		KIND_READ,
		KIND_DRAW,
		KIND_CLEAR
	} pfb_kind_t;

	// Pixel update applied on each drawn pixel
	typedef enum logic [1:0] {
		PIX_SET,
		PIX_CLEAR,
		PIX_TOGGLE
	} pfb_pix_mode_t;

	// Engine states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SWEEP,
		BK_RDATA,
		BK_DRAW,
		BK_FINISH
	} pfb_bk_state_t;

	// Request word
	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] col_a;
		logic [7:0] row_a;
		logic [7:0] col_b;
		logic [7:0] row_b;
		logic [7:0] page_index;
		logic [7:0] write_data;
	} pfb_in_t;

	// Result word
	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] status;
	} pfb_out_t;

	// Classified command held in the queue
	typedef struct packed {
		pfb_kind_t     kind;
		pfb_pix_mode_t mode;
		logic          all_pages;
		pfb_status_t   status;
		logic [7:0]    col_a;
		logic [7:0]    row_a;
		logic [7:0]    col_b;
		logic [7:0]    row_b;
		logic [7:0]    page;
		logic [7:0]    data;
	} pfb_cmd_t;

	// Queue head as seen by the engine
	typedef struct packed {
		logic     valid;
		pfb_cmd_t cmd;
	} pfb_head_t;

endpackage

FILE: rtl/paged_frame_buffer_line_draw_unit.sv
// Paged monochrome frame buffer with byte, pixel, line and clear commands.
// Depends on pfb_pkg, pfb_front, pfb_queue and pfb_back.
//
// A command word is taken when start is high and busy is low; each command
// gives exactly one result word, shown for one cycle with done high. The
// receiver cannot hold a result off, so it must take every word on the cycle
// that done is high. The frame holds PAGES pages of COLUMNS bytes, each byte
// eight vertical pixels.
// After reset busy stays high while the memory is cleared one byte per
// cycle. Up to two commands wait in a queue in front of the engine; busy is
// high while that queue is full. The engine handles one command at a time,
// bound by the single frame memory write port: a line does one pixel
// read-modify-write per cycle (at most 256 pixels), and clear page and
// clear all zero one page or every page in turn. The result is registered
// and follows in the cycle after the engine finishes.
`timescale 1ns / 1ps

module paged_frame_buffer_line_draw_unit #(
	parameter int COLUMNS = 162,
	parameter int PAGES   = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pfb_pkg::pfb_in_t  request,
	output logic              done,
	output pfb_pkg::pfb_out_t result
);
	import pfb_pkg::*;

	pfb_cmd_t  cmd;
	pfb_head_t head;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      init_busy;

	// classify incoming words
	pfb_front #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES)
	) u_front (
		.start    (start),
		.request  (request),
		.q_full   (q_full),
		.init_busy(init_busy),
		.busy     (busy),
		.push     (push),
		.cmd      (cmd)
	);

	// decouple front end and engine
	pfb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(cmd),
		.pop     (pop),
		.head    (head),
		.full    (q_full)
	);

	// execute commands on the frame memory
	pfb_back #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.init_busy(init_busy),
		.done     (done),
		.result   (result)
	);

endmodule

FILE: rtl/pfb_queue.sv
// Two-entry command queue between front end and engine.
// Depends on pfb_pkg for the command type.
`timescale 1ns / 1ps

module pfb_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pfb_pkg::pfb_cmd_t push_cmd,
	input  logic             pop,
	output pfb_pkg::pfb_head_t head,
	output logic             full
);
	import pfb_pkg::*;

	pfb_cmd_t   entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// storage, no reset on payload
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = entries_q[rd_ptr_q];
	assign full       = (count_q == 2'd2);

endmodule

FILE: rtl/pfb_front.sv
// Front end: takes request words, range-checks them and turns each into a command.
// Depends on pfb_pkg for request and command types.
`timescale 1ns / 1ps

module pfb_front #(
	parameter int COLUMNS = 162,
	parameter int PAGES   = 8
) (
	input  logic              start,
	input  pfb_pkg::pfb_in_t  request,
	input  logic              q_full,
	input  logic              init_busy,
	output logic              busy,
	output logic              push,
	output pfb_pkg::pfb_cmd_t cmd
);
	import pfb_pkg::*;

	localparam logic [8:0] COL_LIM  = 9'(COLUMNS);
	localparam logic [8:0] ROW_LIM  = 9'(PAGES * 8);
	localparam logic [8:0] PAGE_LIM = 9'(PAGES);

	logic col_a_bad;
	logic col_b_bad;
	logic row_a_bad;
	logic row_b_bad;
	logic page_bad;

	assign busy = q_full | init_busy;
	assign push = start & ~busy;

	// range checks
	assign col_a_bad = ({1'b0, request.col_a} >= COL_LIM);
	assign col_b_bad = ({1'b0, request.col_b} >= COL_LIM);
	assign row_a_bad = ({1'b0, request.row_a} >= ROW_LIM);
	assign row_b_bad = ({1'b0, request.row_b} >= ROW_LIM);
	assign page_bad  = ({1'b0, request.page_index} >= PAGE_LIM);

	// opcode decode; a failed check becomes a status-only command
	always_comb begin
		cmd.kind      = KIND_STATUS;
		cmd.mode      = PIX_TOGGLE;
		cmd.all_pages = 1'b0;
		cmd.status    = ST_OK;
		cmd.col_a     = request.col_a;
		cmd.row_a     = request.row_a;
		cmd.col_b     = request.col_b;
		cmd.row_b     = request.row_b;
		cmd.page      = request.page_index;
		cmd.data      = request.write_data;
		unique case (pfb_op_t'(request.opcode))
			OP_WRITE_BYTE, OP_READ_BYTE: begin
				if (col_a_bad) begin
					cmd.status = ST_BAD_COL_A;
				end else if (page_bad) begin
					cmd.status = ST_BAD_ROW_A;
				end else if (pfb_op_t'(request.opcode) == OP_WRITE_BYTE) begin
					cmd.kind = KIND_WRITE;
				end else begin
					cmd.kind = KIND_READ;
				end
			end
			OP_PIXEL_ON, OP_PIXEL_OFF, OP_PIXEL_TOGGLE: begin
				// single pixel is a line of one point
				cmd.col_b = request.col_a;
				cmd.row_b = request.row_a;
				if (pfb_op_t'(request.opcode) == OP_PIXEL_ON) begin
					cmd.mode = PIX_SET;
				end else if (pfb_op_t'(request.opcode) == OP_PIXEL_OFF) begin
					cmd.mode = PIX_CLEAR;
				end
				if (col_a_bad) begin
					cmd.status = ST_BAD_COL_A;
				end else if (row_a_bad) begin
					cmd.status = ST_BAD_ROW_A;
				end else begin
					cmd.kind = KIND_DRAW;
				end
			end
			OP_LINE: begin
				if (col_a_bad) begin
					cmd.status = ST_BAD_COL_A;
				end else if (col_b_bad) begin
					cmd.status = ST_BAD_COL_B;
				end else if (row_a_bad) begin
					cmd.status = ST_BAD_ROW_A;
				end else if (row_b_bad) begin
					cmd.status = ST_BAD_ROW_B;
				end else begin
					cmd.kind = KIND_DRAW;
				end
			end
			OP_CLEAR_ALL: begin
				cmd.kind      = KIND_CLEAR;
				cmd.all_pages = 1'b1;
			end
			OP_CLEAR_PAGE: begin
				if (page_bad) begin
					cmd.status = ST_BAD_ROW_A;
				end else begin
					cmd.kind = KIND_CLEAR;
				end
			end
			default: begin
				cmd.kind = KIND_STATUS;
			end
		endcase
	end

endmodule

FILE: rtl/pfb_back.sv
// Engine: frame memory, line stepper with read-modify-write pipeline, clear sweeps.
// Depends on pfb_pkg for command, result and state types.
`timescale 1ns / 1ps

module pfb_back #(
	parameter int COLUMNS = 162,
	parameter int PAGES   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pfb_pkg::pfb_head_t head,
	output logic               pop,
	output logic               init_busy,
	output logic               done,
	output pfb_pkg::pfb_out_t  result
);
	import pfb_pkg::*;

	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int AW    = PW + CW;
	localparam int DEPTH = 1 << AW;
	localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
	localparam logic [PW-1:0] LAST_PAGE = PW'(PAGES - 1);

	// frame memory: one write and one registered read port
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic          re;
	logic [AW-1:0] raddr;

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	pfb_bk_state_t state_q;
	pfb_bk_state_t state_d;
	logic          init_q;

	// line stepper state
	logic [7:0]        x_q, y_q, x1_q, y1_q, dx_q, dy_q;
	logic              sxn_q, syn_q, steep_q;
	logic signed [10:0] acc_q;
	pfb_pix_mode_t     mode_q;

	// clear sweep state
	logic [PW-1:0] sw_page_q;
	logic [PW-1:0] sw_hi_q;
	logic [CW-1:0] sw_col_q;

	// write stage of the pixel pipeline
	logic          vld_s1;
	logic [AW-1:0] addr_s1;
	logic [2:0]    bit_s1;
	pfb_pix_mode_t mode_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_data_s1;

	logic     done_q;
	pfb_out_t result_q;

	logic     gen_load, gen_step, gen_end, issue;
	logic     sw_load, sw_step, sweep_end;
	logic     reply_en;
	pfb_out_t reply;

	logic [AW-1:0] head_addr, gen_addr, sweep_addr;
	logic [7:0]    dx_ld, dy_ld;
	logic [7:0]    x_inc, y_inc, x_nx, y_nx;
	logic signed [10:0] two_dx, two_dy, dx_ext, dy_ext, acc_sum, acc_nx;
	logic [7:0]    old_val, bit_mask, new_val;

	// addresses
	assign head_addr  = {head.cmd.page[PW-1:0], head.cmd.col_a[CW-1:0]};
	assign gen_addr   = {y_q[PW+2:3], x_q[CW-1:0]};
	assign sweep_addr = {sw_page_q, sw_col_q};

	// line setup from the queue head
	assign dx_ld = (head.cmd.col_b >= head.cmd.col_a) ? (head.cmd.col_b - head.cmd.col_a)
	                                                  : (head.cmd.col_a - head.cmd.col_b);
	assign dy_ld = (head.cmd.row_b >= head.cmd.row_a) ? (head.cmd.row_b - head.cmd.row_a)
	                                                  : (head.cmd.row_a - head.cmd.row_b);

	// one Bresenham step
	assign two_dx  = signed'({2'b00, dx_q, 1'b0});
	assign two_dy  = signed'({2'b00, dy_q, 1'b0});
	assign dx_ext  = signed'({3'b000, dx_q});
	assign dy_ext  = signed'({3'b000, dy_q});
	assign x_inc   = sxn_q ? 8'hFF : 8'h01;
	assign y_inc   = syn_q ? 8'hFF : 8'h01;
	assign gen_end = steep_q ? (y_q == y1_q) : (x_q == x1_q);

	always_comb begin
		x_nx = x_q;
		y_nx = y_q;
		if (!steep_q) begin
			x_nx    = x_q + x_inc;
			acc_sum = acc_q + two_dy;
			if (acc_sum > dx_ext) begin
				y_nx   = y_q + y_inc;
				acc_nx = acc_sum - two_dx;
			end else begin
				acc_nx = acc_sum;
			end
		end else begin
			y_nx    = y_q + y_inc;
			acc_sum = acc_q + two_dx;
			if (acc_sum > dy_ext) begin
				x_nx   = x_q + x_inc;
				acc_nx = acc_sum - two_dy;
			end else begin
				acc_nx = acc_sum;
			end
		end
	end

	// pixel modify, forwarding the write of the previous pixel
	assign old_val  = fwd_s1 ? fwd_data_s1 : rdata_q;
	assign bit_mask = 8'h01 << bit_s1;
	always_comb begin
		unique case (mode_s1)
			PIX_SET:   new_val = old_val | bit_mask;
			PIX_CLEAR: new_val = old_val & ~bit_mask;
			default:   new_val = old_val ^ bit_mask;
		endcase
	end

	assign sweep_end = (sw_col_q == LAST_COL) && (sw_page_q == sw_hi_q);

	// engine control
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		re       = 1'b0;
		raddr    = gen_addr;
		we       = vld_s1;
		waddr    = addr_s1;
		wdata    = new_val;
		issue    = 1'b0;
		gen_load = 1'b0;
		gen_step = 1'b0;
		sw_load  = 1'b0;
		sw_step  = 1'b0;
		reply_en = 1'b0;
		reply.read_data = 8'h00;
		reply.status    = ST_OK;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (head.cmd.kind)
						KIND_WRITE: begin
							we       = 1'b1;
							waddr    = head_addr;
							wdata    = head.cmd.data;
							reply_en = 1'b1;
						end
						KIND_READ: begin
							re      = 1'b1;
							raddr   = head_addr;
							state_d = BK_RDATA;
						end
						KIND_DRAW: begin
							gen_load = 1'b1;
							state_d  = BK_DRAW;
						end
						KIND_CLEAR: begin
							sw_load = 1'b1;
							state_d = BK_SWEEP;
						end
						default: begin
							reply_en     = 1'b1;
							reply.status = head.cmd.status;
						end
					endcase
				end
			end
			BK_RDATA: begin
				reply_en        = 1'b1;
				reply.read_data = rdata_q;
				state_d         = BK_IDLE;
			end
			BK_DRAW: begin
				issue = 1'b1;
				re    = 1'b1;
				raddr = gen_addr;
				if (gen_end) begin
					state_d = BK_FINISH;
				end else begin
					gen_step = 1'b1;
				end
			end
			BK_FINISH: begin
				reply_en = 1'b1;
				state_d  = BK_IDLE;
			end
			BK_SWEEP: begin
				we    = 1'b1;
				waddr = sweep_addr;
				wdata = 8'h00;
				if (sweep_end) begin
					reply_en = ~init_q;
					state_d  = BK_IDLE;
				end else begin
					sw_step = 1'b1;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// control registers; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_SWEEP;
			init_q    <= 1'b1;
			sw_page_q <= '0;
			sw_hi_q   <= LAST_PAGE;
			sw_col_q  <= '0;
			vld_s1    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			done_q  <= reply_en;
			if (state_q == BK_SWEEP && sweep_end) begin
				init_q <= 1'b0;
			end
			if (sw_load) begin
				sw_col_q  <= '0;
				sw_page_q <= head.cmd.all_pages ? '0 : head.cmd.page[PW-1:0];
				sw_hi_q   <= head.cmd.all_pages ? LAST_PAGE : head.cmd.page[PW-1:0];
			end else if (sw_step) begin
				if (sw_col_q == LAST_COL) begin
					sw_col_q  <= '0;
					sw_page_q <= sw_page_q + 1'b1;
				end else begin
					sw_col_q <= sw_col_q + 1'b1;
				end
			end
		end
	end

	// stepper and pipeline payload
	always_ff @(posedge clk) begin
		if (gen_load) begin
			x_q     <= head.cmd.col_a;
			y_q     <= head.cmd.row_a;
			x1_q    <= head.cmd.col_b;
			y1_q    <= head.cmd.row_b;
			dx_q    <= dx_ld;
			dy_q    <= dy_ld;
			sxn_q   <= (head.cmd.col_b < head.cmd.col_a);
			syn_q   <= (head.cmd.row_b < head.cmd.row_a);
			steep_q <= (dy_ld > dx_ld);
			acc_q   <= '0;
			mode_q  <= head.cmd.mode;
		end else if (gen_step) begin
			x_q   <= x_nx;
			y_q   <= y_nx;
			acc_q <= acc_nx;
		end
		addr_s1     <= gen_addr;
		bit_s1      <= y_q[2:0];
		mode_s1     <= mode_q;
		fwd_s1      <= vld_s1 && (addr_s1 == gen_addr);
		fwd_data_s1 <= new_val;
		if (reply_en) begin
			result_q <= reply;
		end
	end

	assign init_busy = init_q;
	assign done      = done_q;
	assign result    = result_q;

endmodule

FILE: rtl/pfb_checker.sv
// Port-level checker for the line draw unit, bound to the top level.
// Depends on pfb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "paged_frame_buffer_line_draw_unit_macros.svh"

module pfb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input pfb_pkg::pfb_in_t  request,
	input logic              done,
	input pfb_pkg::pfb_out_t result
);
	import pfb_pkg::*;

	logic [2:0] pending_q;
	logic       accept;

	assign accept = start & ~busy;

	// words taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			case ({accept, done})
				2'b10:   pending_q <= pending_q + 3'd1;
				2'b01:   pending_q <= pending_q - 3'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	`PFB_ASSERT_IMP(a_status_range, done, result.status <= ST_BAD_ROW_B, "status code out of range")
	`PFB_ASSERT_IMP(a_err_no_data, done && result.status != ST_OK, result.read_data == 8'h00, "read data on rejected word")
	`PFB_ASSERT_IMP(a_no_extra_result, done, pending_q != 3'd0, "result without a pending word")
	`PFB_ASSERT_IMP(a_pending_bound, 1'b1, pending_q <= 3'd4, "too many words in flight")
	`PFB_ASSERT_NEXT(a_accept_counted, accept && (request.opcode == request.opcode), pending_q != 3'd0, "accepted word lost")

endmodule

bind paged_frame_buffer_line_draw_unit pfb_checker u_pfb_checker (.*);

FILE: tb/paged_frame_buffer_line_draw_unit_tb.sv
// Self-checking testbench for the paged frame buffer line draw unit.
// Depends on pfb_pkg and paged_frame_buffer_line_draw_unit; keeps its own frame copy.
`timescale 1ns / 1ps

module paged_frame_buffer_line_draw_unit_tb;
	import pfb_pkg::*;

	localparam int COLS = 162;
	localparam int PAGES = 8;
	localparam int ROWS = PAGES * 8;
	localparam int RANDOM_WORDS = 1500;

	// One queued command word with its pacing hints
	typedef struct {
		pfb_in_t word;
		bit      drain;
		int      phase;
	} cmd_entry_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	pfb_in_t  request = '0;
	logic     done;
	pfb_out_t result;

	cmd_entry_t cmd_q[$];
	pfb_out_t   pending_results[$];
	logic [7:0] frame_copy [PAGES][COLS];

	int in_flight = 0;
	int accepted = 0;
	int checked = 0;
	int errors = 0;
	int cycles = 0;
	int cycle_limit = 0;
	int cost_sum = 0;
	int cur_phase = 0;
	int op_seen [8];

	paged_frame_buffer_line_draw_unit #(
		.COLUMNS(COLS),
		.PAGES(PAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------- frame prediction ----------------

	// Set, clear or toggle one pixel of the frame copy
	function automatic void pixel_update(int col, int row, pfb_pix_mode_t mode);
		logic [7:0] bit_mask;
		bit_mask = 8'd1 << (row % 8);
		case (mode)
			PIX_SET: frame_copy[row / 8][col] |= bit_mask;
			PIX_CLEAR: frame_copy[row / 8][col] &= ~bit_mask;
			default: frame_copy[row / 8][col] ^= bit_mask;
		endcase
	endfunction

	// Bresenham walk, toggling every pixel, both ends included
	function automatic void trace_line(int x0, int y0, int x1, int y1);
		int dx, dy, sx, sy, x, y, acc;
		dx = x1 - x0;
		dy = y1 - y0;
		sx = 1;
		sy = 1;
		x = x0;
		y = y0;
		acc = 0;
		if (dx < 0) begin
			sx = -1;
			dx = -dx;
		end
		if (dy < 0) begin
			sy = -1;
			dy = -dy;
		end
		pixel_update(x, y, PIX_TOGGLE);
		if (dy <= dx) begin
			while (x != x1) begin
				x += sx;
				acc += 2 * dy;
				if (acc > dx) begin
					y += sy;
					acc -= 2 * dx;
				end
				pixel_update(x, y, PIX_TOGGLE);
			end
		end else begin
			while (y != y1) begin
				y += sy;
				acc += 2 * dx;
				if (acc > dy) begin
					x += sx;
					acc -= 2 * dy;
				end
				pixel_update(x, y, PIX_TOGGLE);
			end
		end
	endfunction

	// Apply one command to the frame copy and return the result word it gives
	function automatic pfb_out_t frame_command(pfb_in_t w);
		pfb_out_t    r;
		pfb_status_t st;
		st = ST_OK;
		r = '0;
		case (pfb_op_t'(w.opcode))
			OP_WRITE_BYTE, OP_READ_BYTE: begin
				if (w.col_a >= COLS) st = ST_BAD_COL_A;
				else if (w.page_index >= PAGES) st = ST_BAD_ROW_A;
				else if (pfb_op_t'(w.opcode) == OP_WRITE_BYTE)
					frame_copy[w.page_index][w.col_a] = w.write_data;
				else
					r.read_data = frame_copy[w.page_index][w.col_a];
			end
			OP_PIXEL_ON, OP_PIXEL_OFF, OP_PIXEL_TOGGLE: begin
				if (w.col_a >= COLS) st = ST_BAD_COL_A;
				else if (w.row_a >= ROWS) st = ST_BAD_ROW_A;
				else if (pfb_op_t'(w.opcode) == OP_PIXEL_ON)
					pixel_update(w.col_a, w.row_a, PIX_SET);
				else if (pfb_op_t'(w.opcode) == OP_PIXEL_OFF)
					pixel_update(w.col_a, w.row_a, PIX_CLEAR);
				else
					pixel_update(w.col_a, w.row_a, PIX_TOGGLE);
			end
			OP_LINE: begin
				if (w.col_a >= COLS) st = ST_BAD_COL_A;
				else if (w.col_b >= COLS) st = ST_BAD_COL_B;
				else if (w.row_a >= ROWS) st = ST_BAD_ROW_A;
				else if (w.row_b >= ROWS) st = ST_BAD_ROW_B;
				else trace_line(w.col_a, w.row_a, w.col_b, w.row_b);
			end
			OP_CLEAR_ALL: begin
				foreach (frame_copy[p, c]) frame_copy[p][c] = 8'h00;
			end
			default: begin
				if (w.page_index >= PAGES) st = ST_BAD_ROW_A;
				else for (int c = 0; c < COLS; c++) frame_copy[w.page_index][c] = 8'h00;
			end
		endcase
		r.status = st;
		return r;
	endfunction

	// ---------------- stimulus building ----------------

	function automatic pfb_in_t mk(pfb_op_t op, int ca, int ra, int cb, int rb, int pg,
			int wd);
		pfb_in_t w;
		w.opcode = op;
		w.col_a = 8'(ca);
		w.row_a = 8'(ra);
		w.col_b = 8'(cb);
		w.row_b = 8'(rb);
		w.page_index = 8'(pg);
		w.write_data = 8'(wd);
		return w;
	endfunction

	// Queue a word and add its worst-case engine time to the run budget
	function automatic void add_cmd(pfb_in_t w, bit drain);
		cmd_entry_t e;
		e.word = w;
		e.drain = drain;
		e.phase = cur_phase;
		cmd_q.push_back(e);
		case (pfb_op_t'(w.opcode))
			OP_CLEAR_ALL: cost_sum += PAGES * COLS + 8;
			OP_CLEAR_PAGE: cost_sum += COLS + 8;
			OP_LINE: cost_sum += COLS + 12;
			default: cost_sum += 8;
		endcase
		cost_sum += 12;
	endfunction

	// Mostly in range, now and then any 8-bit value
	function automatic int pick(int lim);
		if ($urandom_range(9) != 0) return $urandom_range(lim - 1);
		return $urandom_range(255);
	endfunction

	function automatic pfb_in_t random_cmd();
		pfb_in_t     w;
		int          r, ca, ra, cb, rb;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		w = raw[$bits(pfb_in_t)-1:0];
		r = $urandom_range(99);
		if (r < 14) begin
			w.opcode = OP_WRITE_BYTE;
			w.col_a = 8'(pick(COLS));
			w.page_index = 8'(pick(PAGES));
		end else if (r < 38) begin
			w.opcode = OP_READ_BYTE;
			w.col_a = 8'(pick(COLS));
			w.page_index = 8'(pick(PAGES));
		end else if (r < 45) begin
			w.opcode = OP_PIXEL_ON;
			w.col_a = 8'(pick(COLS));
			w.row_a = 8'(pick(ROWS));
		end else if (r < 52) begin
			w.opcode = OP_PIXEL_OFF;
			w.col_a = 8'(pick(COLS));
			w.row_a = 8'(pick(ROWS));
		end else if (r < 59) begin
			w.opcode = OP_PIXEL_TOGGLE;
			w.col_a = 8'(pick(COLS));
			w.row_a = 8'(pick(ROWS));
		end else if (r < 91) begin
			w.opcode = OP_LINE;
			ca = $urandom_range(COLS - 1);
			ra = $urandom_range(ROWS - 1);
			// short segments mostly, freely placed ends the rest of the time
			if ($urandom_range(9) < 6) begin
				cb = ca + $urandom_range(24) - 12;
				rb = ra + $urandom_range(24) - 12;
				if (cb < 0) cb = 0;
				if (cb > COLS - 1) cb = COLS - 1;
				if (rb < 0) rb = 0;
				if (rb > ROWS - 1) rb = ROWS - 1;
			end else begin
				cb = $urandom_range(COLS - 1);
				rb = $urandom_range(ROWS - 1);
			end
			// break one endpoint field in some lines
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0: ca = $urandom_range(255, COLS);
					1: cb = $urandom_range(255, COLS);
					2: ra = $urandom_range(255, ROWS);
					default: rb = $urandom_range(255, ROWS);
				endcase
			end
			w.col_a = 8'(ca);
			w.row_a = 8'(ra);
			w.col_b = 8'(cb);
			w.row_b = 8'(rb);
		end else if (r < 93) begin
			w.opcode = OP_CLEAR_ALL;
		end else begin
			w.opcode = OP_CLEAR_PAGE;
			w.page_index = 8'(pick(PAGES));
		end
		return w;
	endfunction

	// ---------------- driver ----------------

	always @(posedge clk) begin : drive
		cmd_entry_t nxt;
		int         idle_pct;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (done) in_flight--;
			if (start && !busy) begin
				pending_results.push_back(frame_command(request));
				op_seen[request.opcode]++;
				in_flight++;
				accepted++;
			end
			if (!start || !busy) begin
				if (cmd_q.size() == 0) begin
					start <= 1'b0;
				end else begin
					nxt = cmd_q[0];
					idle_pct = (nxt.phase == 0) ? 22 : (nxt.phase == 1) ? 48 : 0;
					if ((nxt.drain && in_flight != 0) || $urandom_range(99) < idle_pct) begin
						start <= 1'b0;
					end else begin
						request <= nxt.word;
						start <= 1'b1;
						void'(cmd_q.pop_front());
					end
				end
			end
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin : watch
		pfb_out_t exp_word;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: read_data %0h status %0d",
					result.read_data, result.status);
				errors++;
			end else begin
				exp_word = pending_results.pop_front();
				checked++;
				if (result.read_data !== exp_word.read_data) begin
					$error("read_data mismatch: expected %0h, got %0h",
						exp_word.read_data, result.read_data);
					errors++;
				end
				if (result.status !== exp_word.status) begin
					$error("status mismatch: expected %0d, got %0d",
						exp_word.status, result.status);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycle_limit > 0 && cycles > cycle_limit) begin
			$display("timeout after %0d cycles", cycles);
			$display("paged_frame_buffer_line_draw_unit_tb NOT OK");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		foreach (frame_copy[p, c]) frame_copy[p][c] = 8'h00;
		foreach (op_seen[i]) op_seen[i] = 0;

		// directed: extremes, every opcode, each rejection path
		add_cmd(mk(OP_WRITE_BYTE, 0, 0, 0, 0, 0, 8'hFF), 0);
		add_cmd(mk(OP_WRITE_BYTE, COLS - 1, 0, 0, 0, PAGES - 1, 8'hA5), 0);
		add_cmd(mk(OP_READ_BYTE, 0, 0, 0, 0, 0, 0), 0);
		add_cmd(mk(OP_READ_BYTE, COLS - 1, 0, 0, 0, PAGES - 1, 0), 0);
		add_cmd(mk(OP_WRITE_BYTE, COLS, 0, 0, 0, 0, 8'h5A), 0);
		add_cmd(mk(OP_WRITE_BYTE, 0, 0, 0, 0, PAGES, 8'h5A), 0);
		add_cmd(mk(OP_READ_BYTE, 255, 255, 255, 255, 255, 255), 0);
		add_cmd(mk(OP_READ_BYTE, 5, 0, 0, 0, 255, 0), 0);
		add_cmd(mk(OP_PIXEL_ON, 3, 5, 0, 0, 0, 0), 0);
		add_cmd(mk(OP_PIXEL_OFF, COLS - 1, ROWS - 1, 0, 0, 0, 0), 0);
		add_cmd(mk(OP_PIXEL_TOGGLE, 80, 40, 0, 0, 0, 0), 0);
		add_cmd(mk(OP_PIXEL_ON, COLS, 0, 0, 0, 0, 0), 0);
		add_cmd(mk(OP_PIXEL_OFF, 0, ROWS, 0, 0, 0, 0), 0);
		add_cmd(mk(OP_PIXEL_TOGGLE, 255, 255, 0, 0, 0, 0), 0);
		add_cmd(mk(OP_LINE, 0, 0, COLS - 1, ROWS - 1, 0, 0), 0);
		add_cmd(mk(OP_LINE, COLS - 1, 0, 0, ROWS - 1, 0, 0), 0);
		add_cmd(mk(OP_LINE, 20, 60, 25, 2, 0, 0), 0);
		add_cmd(mk(OP_LINE, 7, 7, 7, 7, 0, 0), 0);
		add_cmd(mk(OP_LINE, COLS, 300 % 256, 255, 255, 0, 0), 0);
		add_cmd(mk(OP_LINE, 10, ROWS, 200, 0, 0, 0), 0);
		add_cmd(mk(OP_LINE, 10, ROWS, 20, 0, 0, 0), 0);
		add_cmd(mk(OP_LINE, 10, 5, 20, 255, 0, 0), 0);
		add_cmd(mk(OP_READ_BYTE, 80, 0, 0, 0, 5, 0), 0);
		add_cmd(mk(OP_CLEAR_PAGE, 0, 0, 0, 0, PAGES - 1, 0), 0);
		add_cmd(mk(OP_CLEAR_PAGE, 0, 0, 0, 0, PAGES, 0), 0);
		add_cmd(mk(OP_CLEAR_ALL, 0, 0, 0, 0, 255, 0), 0);

		// random part in three pacing phases, draining at each boundary
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			cur_phase = (i * 3) / RANDOM_WORDS;
			add_cmd(random_cmd(), (i % (RANDOM_WORDS / 3) == 0) || $urandom_range(99) == 0);
		end
		add_cmd(mk(OP_READ_BYTE, 0, 0, 0, 0, 0, 0), 1);

		cycle_limit = 4 * cost_sum + 4 * PAGES * COLS + 2000;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start || in_flight != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d expected result words never arrived", pending_results.size());
			errors++;
		end

		$display("%0d words sent: %0d lines, %0d byte reads, %0d byte writes, %0d pixel ops,",
			accepted, op_seen[OP_LINE], op_seen[OP_READ_BYTE], op_seen[OP_WRITE_BYTE],
			op_seen[OP_PIXEL_ON] + op_seen[OP_PIXEL_OFF] + op_seen[OP_PIXEL_TOGGLE]);
		$display("%0d page clears, %0d full clears; %0d results checked in %0d cycles",
			op_seen[OP_CLEAR_PAGE], op_seen[OP_CLEAR_ALL], checked, cycles);
		if (errors == 0) begin
			$display("paged_frame_buffer_line_draw_unit_tb OK");
		end else begin
			$display("paged_frame_buffer_line_draw_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
